/* rtl/bleadv_pkg.sv */
// Shared types and constants for the BLE advertisement sensor decoder.
// Used by every module in rtl/. Depends on nothing.
package bleadv_pkg;

  localparam int CapDepth = 6;

  // Parse phase codes
  localparam logic [2:0] PH_LEN     = 3'd0;
  localparam logic [2:0] PH_TYPE    = 3'd1;
  localparam logic [2:0] PH_BODY    = 3'd2;
  localparam logic [2:0] PH_STOPPED = 3'd3;
  localparam logic [2:0] PH_DONE    = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOTFOUND  = 2'd1;
  localparam logic [1:0] ST_MALFORMED = 2'd2;
  localparam logic [1:0] ST_RANGE     = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] CFG_MFR_TYPE = 3'd0;
  localparam logic [2:0] CFG_MIN_TEMP = 3'd1;
  localparam logic [2:0] CFG_MAX_TEMP = 3'd2;
  localparam logic [2:0] CFG_MAX_HUM  = 3'd3;
  localparam logic [2:0] CFG_MAX_BAT  = 3'd4;

  // Reset values of the configuration registers
  localparam logic [7:0]         RST_MFR_TYPE = 8'd255;
  localparam logic signed [15:0] RST_MIN_TEMP = -16'sd500;
  localparam logic signed [15:0] RST_MAX_TEMP = 16'sd1000;
  localparam logic [7:0]         RST_MAX_HUM  = 8'd100;
  localparam logic [7:0]         RST_MAX_BAT  = 8'd100;

  typedef struct packed {
    logic [7:0] adv_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [15:0] temperature_tenths;
    logic [7:0]         rel_humidity;
    logic [7:0]         battery_level;
  } out_item_t;

  typedef struct packed {
    logic [7:0]         mfr_type;
    logic signed [15:0] min_temp;
    logic signed [15:0] max_temp;
    logic [7:0]         max_hum;
    logic [7:0]         max_bat;
  } cfg_t;

  typedef struct packed {
    logic [2:0] phase;
    logic [7:0] remaining;
    logic [2:0] body_pos;
    logic       is_mfr;
    logic       saw_mfr;
    logic       saw_complete;
  } walk_t;

  typedef logic [CapDepth-1:0][7:0] cap_t;

  localparam walk_t WALK_RESET = '{
    phase: PH_LEN, remaining: 8'd0, body_pos: 3'd0,
    is_mfr: 1'b0, saw_mfr: 1'b0, saw_complete: 1'b0
  };

  // Range check of one sensor payload: temperature low byte, high byte, humidity, battery
  function automatic logic payload_ok(input cfg_t cfg, input logic [7:0] t_lo,
                                      input logic [7:0] t_hi, input logic [7:0] hum,
                                      input logic [7:0] bat);
    logic signed [15:0] temp;
    temp = $signed({t_hi, t_lo});
    return (temp >= cfg.min_temp) && (temp <= cfg.max_temp) &&
           (hum <= cfg.max_hum) && (bat <= cfg.max_bat);
  endfunction

endpackage

/* rtl/bleadv_step.sv */
// Per-byte walk logic: next walk state, capture write and result for one item.
// Depends on bleadv_pkg.
module bleadv_step (
  input  bleadv_pkg::cfg_t      cfg,
  input  bleadv_pkg::walk_t     walk,
  input  bleadv_pkg::cap_t      cap,
  input  bleadv_pkg::in_item_t  item,
  output bleadv_pkg::walk_t     walk_next,
  output logic                  cap_we,
  output logic [2:0]            cap_idx,
  output logic                  res_valid,
  output bleadv_pkg::out_item_t res
);
  import bleadv_pkg::*;

  cap_t       view;
  logic [7:0] rem_dec;
  logic       complete;
  logic       mal;
  logic       fin_req;
  logic       try2;
  logic       try0;
  logic       hit;

  always_comb begin
    walk_next = walk;
    cap_we    = 1'b0;
    cap_idx   = 3'd0;
    complete  = 1'b0;
    mal       = 1'b0;
    fin_req   = 1'b0;
    rem_dec   = walk.remaining - 8'd1;

    unique case (walk.phase)
      PH_LEN: begin
        if (item.adv_byte == 8'd0) begin
          walk_next.phase = PH_STOPPED;
          fin_req         = item.last_byte;
        end else begin
          walk_next.remaining = item.adv_byte;
          walk_next.phase     = PH_TYPE;
          mal                 = item.last_byte;
        end
      end
      PH_TYPE: begin
        walk_next.remaining = rem_dec;
        walk_next.is_mfr    = (item.adv_byte == cfg.mfr_type);
        if (item.adv_byte == cfg.mfr_type) begin
          walk_next.saw_mfr = 1'b1;
        end
        walk_next.body_pos = 3'd0;
        if (rem_dec == 8'd0) begin
          complete = 1'b1;
        end else begin
          walk_next.phase = PH_BODY;
          mal             = item.last_byte;
        end
      end
      PH_BODY: begin
        // keep body bytes 1 to 6
        if (walk.body_pos >= 3'd1 && walk.body_pos <= 3'd6) begin
          cap_we  = 1'b1;
          cap_idx = walk.body_pos - 3'd1;
        end
        if (walk.body_pos != 3'd7) begin
          walk_next.body_pos = walk.body_pos + 3'd1;
        end
        walk_next.remaining = rem_dec;
        if (rem_dec == 8'd0) begin
          complete = 1'b1;
        end else begin
          mal = item.last_byte;
        end
      end
      PH_STOPPED: begin
        fin_req = item.last_byte;
      end
      default: begin
      end
    endcase

    // captured bytes as they stand after this item's write
    for (int i = 0; i < CapDepth; i++) begin
      view[i] = (cap_we && cap_idx == 3'(i)) ? item.adv_byte : cap[i];
    end

    try2 = 1'b0;
    try0 = 1'b0;
    if (complete) begin
      walk_next.phase = PH_LEN;
      if (walk_next.is_mfr) begin
        if (walk_next.body_pos >= 3'd5) begin
          walk_next.saw_complete = 1'b1;
        end
        try2 = (walk_next.body_pos == 3'd7) &&
               payload_ok(cfg, view[2], view[3], view[4], view[5]);
        try0 = (walk_next.body_pos >= 3'd5) &&
               payload_ok(cfg, view[0], view[1], view[2], view[3]);
      end
      fin_req = item.last_byte;
    end
    hit = try2 || try0;
    if (hit) begin
      walk_next.phase = PH_DONE;
    end

    res_valid = hit || mal || fin_req;
    res       = '0;
    if (try2) begin
      res.status             = ST_OK;
      res.temperature_tenths = $signed({view[3], view[2]});
      res.rel_humidity       = view[4];
      res.battery_level      = view[5];
    end else if (try0) begin
      res.status             = ST_OK;
      res.temperature_tenths = $signed({view[1], view[0]});
      res.rel_humidity       = view[2];
      res.battery_level      = view[3];
    end else if (mal) begin
      res.status = ST_MALFORMED;
    end else if (!walk_next.saw_mfr) begin
      res.status = ST_NOTFOUND;
    end else if (walk_next.saw_complete) begin
      res.status = ST_RANGE;
    end else begin
      res.status = ST_MALFORMED;
    end

    // end of advertisement: drop the walk state
    if (item.last_byte) begin
      walk_next = WALK_RESET;
    end
  end

endmodule

/* rtl/bleadv_skid.sv */
// Two-entry output buffer: result register plus skid register.
// Depends on bleadv_pkg.
module bleadv_skid (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  bleadv_pkg::out_item_t push_data,
  output logic                  full,
  output logic                  out_valid,
  input  logic                  out_ready,
  output bleadv_pkg::out_item_t out_data
);
  import bleadv_pkg::*;

  logic      main_valid;
  logic      skid_valid;
  out_item_t main_data;
  out_item_t skid_data;
  logic      pop;

  assign pop       = main_valid && out_ready;
  assign full      = skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // no push while the skid entry is held
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid || pop) begin
        main_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        main_data <= skid_data;
      end
    end else if (push) begin
      if (!main_valid || pop) begin
        main_data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end
  end

endmodule

/* rtl/ble_adv_sensor_decoder.sv */
// BLE advertisement sensor decoder, top level. Uses bleadv_pkg, bleadv_step, bleadv_skid.
// Throughput: one advertisement byte per cycle while in_ready is high; the walk state
// updates as the byte is taken; each result is registered before it appears on out_valid.
// Output: a result register with a skid entry; input stalls only when both are full.
// Reset (rst, synchronous): walk state cleared, output empty, registers to defaults.
module ble_adv_sensor_decoder (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  bleadv_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output bleadv_pkg::out_item_t out_data,
  input  logic                  cfg_wr_en,
  input  logic [2:0]            cfg_index,
  input  logic [15:0]           cfg_data
);
  import bleadv_pkg::*;

  cfg_t      cfg;
  walk_t     walk;
  walk_t     walk_next;
  cap_t      cap;
  logic      cap_we;
  logic [2:0] cap_idx;
  logic      res_valid;
  out_item_t res;
  logic      accept;
  logic      buf_full;

  assign in_ready = !buf_full;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mfr_type <= RST_MFR_TYPE;
      cfg.min_temp <= RST_MIN_TEMP;
      cfg.max_temp <= RST_MAX_TEMP;
      cfg.max_hum  <= RST_MAX_HUM;
      cfg.max_bat  <= RST_MAX_BAT;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_MFR_TYPE: cfg.mfr_type <= cfg_data[7:0];
        CFG_MIN_TEMP: cfg.min_temp <= $signed(cfg_data);
        CFG_MAX_TEMP: cfg.max_temp <= $signed(cfg_data);
        CFG_MAX_HUM:  cfg.max_hum  <= cfg_data[7:0];
        CFG_MAX_BAT:  cfg.max_bat  <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk <= WALK_RESET;
    end else if (accept) begin
      walk <= walk_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cap_we) begin
      cap[cap_idx] <= in_data.adv_byte;
    end
  end

  bleadv_step u_step (
    .cfg       (cfg),
    .walk      (walk),
    .cap       (cap),
    .item      (in_data),
    .walk_next (walk_next),
    .cap_we    (cap_we),
    .cap_idx   (cap_idx),
    .res_valid (res_valid),
    .res       (res)
  );

  bleadv_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && res_valid),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
